// File: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int WIN_DEPTH  = 4096;
   localparam int WIN_AW     = $clog2(WIN_DEPTH);
   localparam int BYTES_OUT  = 8;
   localparam int PCNT_W     = (BYTES_OUT > 1) ? $clog2(BYTES_OUT) : 1;
   localparam int LEN_W      = 9;

   localparam logic [7:0]       FILL_BYTE = 8'h30;
   localparam logic [LEN_W-1:0] MIN_MATCH = 9'd3;
   localparam logic [3:0]       LEN_ESC   = 4'hf;

   // decoded action of one accepted compressed word
   typedef struct packed {
      logic              lit;
      logic              match;
      logic [7:0]        data;
      logic [LEN_W-1:0]  len;
      logic [WIN_AW-1:0] offset;
   } cmd_type;

   // copy engine status for the top level
   typedef struct packed {
      logic idle;
      logic pack_empty;
   } stat_type;

endpackage

// File: rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, hold when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/lzwd_parse.sv
// ----------------------------------------------------------------------------
// lzwd_parse
// Flag group parser: tracks flag bits and turns compressed words into
// literal and match commands.
// ----------------------------------------------------------------------------
module lzwd_parse
   import lzwd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic [7:0] extra_length,
   output cmd_type    cmd
);

   localparam logic [1:0] PH_FLAG   = 2'd0;
   localparam logic [1:0] PH_ITEM   = 2'd1;
   localparam logic [1:0] PH_MATCH2 = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] flags_ff, flags_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] first_ff, first_in;
   logic       flag_bit;
   logic [LEN_W-1:0] len_base;

   assign flag_bit = flags_ff[3'd7 - idx_ff];
   assign len_base = LEN_W'(first_ff[7:4]) + MIN_MATCH;

   // decode the word and work out the next parse position
   always_comb begin
      phase_in   = phase_ff;
      flags_in   = flags_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      cmd.lit    = 1'b0;
      cmd.match  = 1'b0;
      cmd.data   = in_byte;
      cmd.len    = (first_ff[7:4] == LEN_ESC) ? len_base + LEN_W'(extra_length) : len_base;
      cmd.offset = {first_ff[3:0], in_byte};
      unique case (phase_ff)
         PH_ITEM: begin
            if (!flag_bit) begin
               cmd.lit = 1'b1;
               if (idx_ff == 3'd7) begin
                  phase_in = PH_FLAG;
                  idx_in   = 3'd0;
               end else begin
                  phase_in = PH_ITEM;
                  idx_in   = idx_ff + 3'd1;
               end
            end else begin
               first_in = in_byte;
               phase_in = PH_MATCH2;
            end
         end
         PH_MATCH2: begin
            cmd.match = 1'b1;
            if (idx_ff == 3'd7) begin
               phase_in = PH_FLAG;
               idx_in   = 3'd0;
            end else begin
               phase_in = PH_ITEM;
               idx_in   = idx_ff + 3'd1;
            end
         end
         default: begin
            flags_in = in_byte;
            idx_in   = 3'd0;
            phase_in = PH_ITEM;
         end
      endcase
   end

   // advance parse state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         flags_ff <= 8'd0;
         idx_ff   <= 3'd0;
         first_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

endmodule

// File: rtl/lzwd_copy.sv
// ----------------------------------------------------------------------------
// lzwd_copy
// Copy engine: one sequencer and one address/count unit that move bytes
// through the history window, pack them and hold the result word.
// ----------------------------------------------------------------------------
module lzwd_copy
   import lzwd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  cmd_type                cmd,
   output logic                   idle,
   output stat_type               stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [8*BYTES_OUT-1:0] rsp_out_bytes,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_last_of_run
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_COPY = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [WIN_AW-1:0]      wp_ff, wp_in;
   logic                   wrapped_ff, wrapped_in;
   logic [WIN_AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic                   dist0_ff, dist0_in;
   logic                   use_last_ff, use_last_in;
   logic                   unw_ff, unw_in;
   logic [7:0]             last_ff, last_in;
   logic [8*BYTES_OUT-1:0] pack_ff, pack_in;
   logic [PCNT_W-1:0]      pcnt_ff, pcnt_in;
   logic                   rv_ff, rv_in;
   logic [8*BYTES_OUT-1:0] rbytes_ff, rbytes_in;
   logic [3:0]             rcount_ff, rcount_in;
   logic                   rlast_ff, rlast_in;

   logic                   ram_we, ram_re;
   logic [WIN_AW-1:0]      ram_raddr;
   logic [7:0]             ram_rdata;
   logic [7:0]             cur;
   logic                   flush, adv;
   logic [8*BYTES_OUT-1:0] lane_val;

   lzwd_ram #(
      .WIDTH (8),
      .DEPTH (WIN_DEPTH)
   ) u_win (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (cur),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // current byte: repeated byte, untouched fill or window data
   always_comb begin
      if (use_last_ff) begin
         cur = last_ff;
      end else if (unw_ff) begin
         cur = FILL_BYTE;
      end else begin
         cur = ram_rdata;
      end
   end

   // drop the current byte into its lane of the pack
   always_comb begin
      lane_val = pack_ff;
      for (int i = 0; i < BYTES_OUT; i++) begin
         if (pcnt_ff == PCNT_W'(i)) begin
            lane_val[8*i +: 8] = cur;
         end
      end
   end

   assign flush = (pcnt_ff == PCNT_W'(BYTES_OUT - 1)) || (rem_ff == LEN_W'(1));
   assign adv   = !flush || !rv_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      wrapped_in  = wrapped_ff;
      rd_addr_in  = rd_addr_ff;
      rem_in      = rem_ff;
      dist0_in    = dist0_ff;
      use_last_in = use_last_ff;
      unw_in      = unw_ff;
      last_in     = last_ff;
      pack_in     = pack_ff;
      pcnt_in     = pcnt_ff;
      rv_in       = rv_ff && !rsp_ready;
      rbytes_in   = rbytes_ff;
      rcount_in   = rcount_ff;
      rlast_in    = rlast_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (go && cmd.lit) begin
               last_in     = cmd.data;
               use_last_in = 1'b1;
               rem_in      = LEN_W'(1);
               state_in    = S_COPY;
            end else if (go && cmd.match) begin
               rd_addr_in = wp_ff - cmd.offset - WIN_AW'(1);
               rem_in     = cmd.len;
               dist0_in   = (cmd.offset == '0);
               state_in   = S_RD;
            end
         end
         S_RD: begin
            ram_re      = 1'b1;
            unw_in      = !wrapped_ff && (rd_addr_ff >= wp_ff);
            use_last_in = 1'b0;
            state_in    = S_COPY;
         end
         S_COPY: begin
            if (adv) begin
               ram_we  = 1'b1;
               wp_in   = wp_ff + WIN_AW'(1);
               last_in = cur;
               if (wp_ff == '1) begin
                  wrapped_in = 1'b1;
               end
               if (flush) begin
                  rv_in     = 1'b1;
                  rbytes_in = lane_val;
                  rcount_in = 4'(pcnt_ff) + 4'd1;
                  rlast_in  = (rem_ff == LEN_W'(1));
                  pack_in   = '0;
                  pcnt_in   = '0;
               end else begin
                  pack_in = lane_val;
                  pcnt_in = pcnt_ff + PCNT_W'(1);
               end
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  // prefetch the next source byte
                  ram_re      = 1'b1;
                  ram_raddr   = rd_addr_ff + WIN_AW'(1);
                  rd_addr_in  = rd_addr_ff + WIN_AW'(1);
                  unw_in      = !wrapped_ff && (ram_raddr >= wp_ff);
                  use_last_in = dist0_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         pcnt_ff    <= '0;
         pack_ff    <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         pcnt_ff    <= pcnt_in;
         pack_ff    <= pack_in;
         rv_ff      <= rv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rem_ff      <= rem_in;
      dist0_ff    <= dist0_in;
      use_last_ff <= use_last_in;
      unw_ff      <= unw_in;
      last_ff     <= last_in;
      rbytes_ff   <= rbytes_in;
      rcount_ff   <= rcount_in;
      rlast_ff    <= rlast_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign stat.idle       = idle;
   assign stat.pack_empty = (pcnt_ff == '0);
   assign rsp_valid       = rv_ff;
   assign rsp_out_bytes   = rbytes_ff;
   assign rsp_byte_count  = rcount_ff;
   assign rsp_last_of_run = rlast_ff;

endmodule

// File: rtl/lzss_window_decoder.sv
// Flag and first match words leave the decoder ready; a literal goes through the copy state
// to the result word. A match goes through a read state, then copies one window byte per
// cycle through the shared window read port and copy counter while no result word stalls.
// Results are packed up to eight bytes; a result word is registered with its last byte.
// Synchronous reset clears parser and pointers; untouched window entries read as 0x30
// through a wrap mark, so no clearing pass is needed and words are taken at once.
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decompressor with a 4 KiB history window, one compressed word in,
// up to eight decoded bytes per result word.
// ----------------------------------------------------------------------------
module lzss_window_decoder
   import lzwd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [8*BYTES_OUT-1:0] rsp_out_bytes,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_last_of_run,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data
);

   logic [7:0] extra_len_ff;
   logic       accept;
   logic       idle;
   cmd_type    cmd;
   stat_type   stat;

   // extra length register
   always_ff @(posedge clock) begin
      if (reset) begin
         extra_len_ff <= 8'd20;
      end else if (csr_wr_en) begin
         extra_len_ff <= csr_wr_data;
      end
   end

   assign req_ready = idle;
   assign accept    = req_valid && req_ready;

   lzwd_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .extra_length (extra_len_ff),
      .cmd          (cmd)
   );

   lzwd_copy u_copy (
      .clock           (clock),
      .reset           (reset),
      .go              (accept),
      .cmd             (cmd),
      .idle            (idle),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_bytes   (rsp_out_bytes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a result word carries one to eight bytes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != 4'd0) && (rsp_byte_count <= 4'(BYTES_OUT)))
      else $error("result byte count out of range");

   // a short result word only ever closes a run
   a_short_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_count != 4'(BYTES_OUT))) |-> rsp_last_of_run)
      else $error("partial result word not marked last");

   // the packer is empty whenever a new word may enter
   a_pack_empty: assert property (@(posedge clock) disable iff (reset)
      stat.idle |-> stat.pack_empty)
      else $error("bytes left in packer while idle");

   // flag and first match words leave the decoder ready
   a_no_work: assert property (@(posedge clock) disable iff (reset)
      (accept && !cmd.lit && !cmd.match) |=> req_ready)
      else $error("decoder busy after word with no output");

endmodule
